/* sv/skvt_pkg.sv */
`default_nettype none

package skvt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_NEGATIVE  = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CHK,
        S_INS_PUT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_REM_RD,
        S_REM_WR,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

endpackage

`default_nettype wire

/* sv/sorted_key_value_table.sv */
// sorted key/value table, ENTRIES pairs kept in ascending key order
//
// input channel: in_valid / in_stall carry operation, key and data_in.
//   a beat is taken when in_valid is high and in_stall is low. in_stall
//   stays high from the accepted beat until its result has been taken.
// output channel: out_valid / out_stall carry status, data_out and
//   table_empty, one result beat per input beat, held while out_stall is high.
// memory: the entries live in a single-port-read, single-port-write memory
//   and one key comparator walks it one entry at a time.
//   negative insert, full insert, empty-table insert, unused op and
//   empty-table lookup or remove go straight to the result; an insert walks
//   from the top entry down, lookup and remove walk up from the front,
//   and a remove then moves each later entry down one place.
// reset: asynchronous, clears the entry count and control; the memory is
//   not cleared, entries at or above the count are never read.
`default_nettype none

module sorted_key_value_table
    import skvt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         operation,
    input  wire logic signed [31:0] key,
    input  wire logic signed [31:0] data_in,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic signed [31:0]      data_out,
    output logic                    table_empty
);

    entry_t               mem [ENTRIES];
    entry_t               rdata_reg;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    op_t                  op_reg, op_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [VAL_W-1:0]     din_reg, din_next;
    status_t              status_reg, status_next;
    logic [VAL_W-1:0]     dout_reg, dout_next;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    entry_t               mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;

    logic                 in_beat;
    logic                 out_beat;
    logic                 key_greater;
    logic                 key_equal;
    logic                 scan_last;
    logic                 rem_last;
    logic [CNT_W-1:0]     count_m1;
    op_t                  in_op;

    assign in_op       = op_t'(operation);
    assign in_beat     = in_valid && !in_stall;
    assign out_beat    = out_valid && !out_stall;
    assign count_m1    = count_reg - CNT_W'(1);
    // stored keys are never negative, so unsigned order is key order
    assign key_greater = rdata_reg.key > key_reg;
    assign key_equal   = rdata_reg.key == key_reg;
    assign scan_last   = CNT_W'(idx_reg) == count_m1;
    assign rem_last    = CNT_W'(idx_reg) + CNT_W'(1) == count_m1;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    if (in_op == OP_INSERT)
                    begin
                        if (key[31] || count_reg == CNT_W'(ENTRIES) || count_reg == '0)
                            state_next = S_OUT;
                        else
                            state_next = S_INS_RD;
                    end
                    else if (in_op inside {OP_LOOKUP, OP_REMOVE})
                    begin
                        if (count_reg == '0)
                            state_next = S_OUT;
                        else
                            state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_INS_RD:   state_next = S_INS_CHK;
            S_INS_CHK:
            begin
                if (!key_greater)
                    state_next = S_OUT;
                else if (idx_reg == IDX_W'(1))
                    state_next = S_INS_PUT;
                else
                    state_next = S_INS_RD;
            end
            S_INS_PUT:  state_next = S_OUT;
            S_SCAN_RD:  state_next = S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                if (key_equal)
                begin
                    if (op_reg == OP_REMOVE && !scan_last)
                        state_next = S_REM_RD;
                    else
                        state_next = S_OUT;
                end
                else if (scan_last)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_REM_RD:   state_next = S_REM_WR;
            S_REM_WR:   state_next = rem_last ? S_OUT : S_REM_RD;
            S_OUT:
            begin
                if (out_beat)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        idx_next    = idx_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        din_next    = din_reg;
        status_next = status_reg;
        dout_next   = dout_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = rdata_reg;
        mem_raddr   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    op_next     = in_op;
                    key_next    = key;
                    din_next    = data_in;
                    status_next = ST_OK;
                    dout_next   = '0;
                    idx_next    = '0;
                    if (in_op == OP_INSERT)
                    begin
                        if (key[31])
                        begin
                            status_next = ST_NEGATIVE;
                        end
                        else if (count_reg == CNT_W'(ENTRIES))
                        begin
                            status_next = ST_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = '0;
                            mem_wdata.key   = key;
                            mem_wdata.value = data_in;
                            count_next      = CNT_W'(1);
                        end
                        else
                        begin
                            idx_next = IDX_W'(count_reg);
                        end
                    end
                    else if (in_op inside {OP_LOOKUP, OP_REMOVE})
                    begin
                        if (count_reg == '0)
                            status_next = ST_NOT_FOUND;
                    end
                end
            end
            S_INS_RD:
            begin
                mem_raddr = idx_reg - IDX_W'(1);
            end
            S_INS_CHK:
            begin
                mem_we = 1'b1;
                if (key_greater)
                begin
                    // move the larger entry up one place
                    idx_next = idx_reg - IDX_W'(1);
                end
                else
                begin
                    mem_wdata.key   = key_reg;
                    mem_wdata.value = din_reg;
                    count_next      = count_reg + CNT_W'(1);
                end
            end
            S_INS_PUT:
            begin
                mem_we          = 1'b1;
                mem_waddr       = '0;
                mem_wdata.key   = key_reg;
                mem_wdata.value = din_reg;
                count_next      = count_reg + CNT_W'(1);
            end
            S_SCAN_CHK:
            begin
                if (key_equal)
                begin
                    dout_next = rdata_reg.value;
                    if (op_reg == OP_REMOVE && scan_last)
                        count_next = count_m1;
                end
                else if (scan_last)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_REM_RD:
            begin
                mem_raddr = idx_reg + IDX_W'(1);
            end
            S_REM_WR:
            begin
                // close the gap one entry at a time
                mem_we   = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
                if (rem_last)
                    count_next = count_m1;
            end
            default:
            begin
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:  in_stall  = 1'b0;
            S_OUT:   out_valid = 1'b1;
            default:
            begin
                in_stall  = 1'b1;
                out_valid = 1'b0;
            end
        endcase
    end

    assign status      = status_reg;
    assign data_out    = dout_reg;
    assign table_empty = count_reg == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        din_reg    <= din_next;
        status_reg <= status_next;
        dout_reg   <= dout_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count above table size");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status_reg == ST_FULL |-> count_reg == CNT_W'(ENTRIES))
        else $error("full reported on a table with free entries");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN_CHK || state_reg == S_REM_WR |-> CNT_W'(idx_reg) < count_reg)
        else $error("scan index beyond valid entries");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op_reg == OP_INSERT && status_reg == ST_OK |-> !table_empty)
        else $error("table empty after a good insert");

    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(count_reg))
        else $error("result or count moved during output stall");
`endif

endmodule

`default_nettype wire

/* dv/tb_sorted_key_value_table.sv */
`timescale 1ns / 1ps

module tb_sorted_key_value_table;
    import skvt_pkg::*;

    typedef struct {
        status_t     st;
        logic [31:0] value;
        logic        empty;
    } result_t;

    typedef struct {
        op_t         op;
        logic [31:0] k;
        logic [31:0] d;
        bit          pinned;
        status_t     st;
        logic [31:0] value;
        bit          empty;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         operation = 2'd0;
    logic signed [31:0] key = '0;
    logic signed [31:0] data_in = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] data_out;
    logic               table_empty;

    // typed-in expectation that rides along with the input beat
    bit      beat_pinned = 1'b0;
    result_t beat_result;

    // shadow copy of the table, kept in key order
    logic [31:0] tbl_key [ENTRIES];
    logic [31:0] tbl_val [ENTRIES];
    int          tbl_count = 0;
    result_t     pending_results[$];

    logic [31:0] key_pool [8];
    int          errors = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_requests = 0;
    int          hold_len = 0;

    sorted_key_value_table dut (.*);

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6000000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    endtask

    function automatic result_t table_apply(op_t op, logic [31:0] k, logic [31:0] d);
        result_t r;
        int      pos;
        int      i;
        r.st = ST_OK;
        r.value = '0;
        case (op)
            OP_INSERT:
            begin
                if (k[31])
                begin
                    r.st = ST_NEGATIVE;
                end
                else if (tbl_count >= ENTRIES)
                begin
                    r.st = ST_FULL;
                end
                else
                begin
                    // equal keys go behind the ones already stored
                    pos = 0;
                    while (pos < tbl_count && tbl_key[pos] <= k) pos++;
                    for (i = tbl_count; i > pos; i--)
                    begin
                        tbl_key[i] = tbl_key[i-1];
                        tbl_val[i] = tbl_val[i-1];
                    end
                    tbl_key[pos] = k;
                    tbl_val[pos] = d;
                    tbl_count++;
                end
            end
            OP_LOOKUP, OP_REMOVE:
            begin
                pos = 0;
                while (pos < tbl_count && tbl_key[pos] != k) pos++;
                if (pos == tbl_count)
                begin
                    r.st = ST_NOT_FOUND;
                end
                else
                begin
                    r.value = tbl_val[pos];
                    if (op == OP_REMOVE)
                    begin
                        for (i = pos; i + 1 < tbl_count; i++)
                        begin
                            tbl_key[i] = tbl_key[i+1];
                            tbl_val[i] = tbl_val[i+1];
                        end
                        tbl_count--;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.empty = (tbl_count == 0);
        return r;
    endfunction

    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result beat", 32'(status), '0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.st)
                        report_mismatch("status", 32'(status), 32'(want.st));
                    if (data_out !== want.value)
                        report_mismatch("data_out", data_out, want.value);
                    if (table_empty !== want.empty)
                        report_mismatch("table_empty", 32'(table_empty), 32'(want.empty));
                end
            end
            if (in_valid && !in_stall)
            begin
                want = table_apply(op_t'(operation), key, data_in);
                if (beat_pinned)
                    want = beat_result;
                pending_results.push_back(want);
            end
        end
    end

    // receiver: random stall, plus a long hold-off when asked for
    initial
    begin : receiver
        int served;
        served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != served)
            begin
                served = hold_requests;
                repeat (hold_len)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_beat(op_t op, logic [31:0] k, logic [31:0] d, bit pinned,
                             result_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        key         <= k;
        data_in     <= d;
        beat_pinned <= pinned;
        beat_result <= want;
        do @(posedge clk); while (in_stall);
    endtask

    // the sender goes quiet, then waits for the last accepted beat's result
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic random_beat(int ins_pct);
        op_t         op;
        logic [31:0] k;
        int          r;
        result_t     none;
        none = '{ST_OK, '0, 1'b0};
        r = $urandom_range(99);
        if (r < 4)
            op = OP_NONE;
        else if (r < 4 + ins_pct)
            op = OP_INSERT;
        else if (r < 4 + ins_pct + (96 - ins_pct) / 2)
            op = OP_LOOKUP;
        else
            op = OP_REMOVE;
        r = $urandom_range(99);
        if (r < 70)
            k = key_pool[$urandom_range(7)];
        else if (r < 80)
            k = {1'b1, 31'($urandom)};
        else if (r < 85)
        begin
            case ($urandom_range(3))
                0: k = 32'h0000_0000;
                1: k = 32'h7fff_ffff;
                2: k = 32'h8000_0000;
                default: k = 32'hffff_ffff;
            endcase
        end
        else
            k = $urandom;
        send_beat(op, k, $urandom, 1'b0, none);
    endtask

    task automatic run_phase(int idle, int stall, int count);
        int i;
        idle_pct = idle;
        stall_pct = stall;
        // small key pool so lookups and removes hit, with duplicate keys
        for (i = 0; i < 8; i++)
            key_pool[i] = ($urandom_range(3) == 0) ? 32'(i) : {1'b0, 31'($urandom)};
        for (i = 0; i < count; i++)
        begin
            // swing between filling and draining the table
            random_beat(((i / 40) % 2 == 0) ? 70 : 25);
        end
        wait_results_drained();
    endtask

    initial
    begin : stimulus
        dir_row_t rows[$];
        result_t  none;
        int       i;
        none = '{ST_OK, '0, 1'b0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back('{OP_LOOKUP, 32'd5, 32'd0, 1'b1, ST_NOT_FOUND, 32'd0, 1'b1});
        rows.push_back('{OP_REMOVE, 32'd5, 32'd0, 1'b1, ST_NOT_FOUND, 32'd0, 1'b1});
        rows.push_back('{OP_NONE, 32'd7, 32'hffff_ffff, 1'b1, ST_OK, 32'd0, 1'b1});
        rows.push_back('{OP_INSERT, 32'hffff_ffff, 32'd1, 1'b1, ST_NEGATIVE, 32'd0, 1'b1});
        rows.push_back('{OP_INSERT, 32'h8000_0000, 32'd1, 1'b1, ST_NEGATIVE, 32'd0, 1'b1});
        rows.push_back('{OP_INSERT, 32'd0, 32'h7fff_ffff, 1'b1, ST_OK, 32'd0, 1'b0});
        rows.push_back('{OP_INSERT, 32'h7fff_ffff, 32'h8000_0000, 1'b1, ST_OK, 32'd0, 1'b0});
        rows.push_back('{OP_INSERT, 32'd0, 32'h1234_5678, 1'b1, ST_OK, 32'd0, 1'b0});
        rows.push_back('{OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 1'b1, ST_OK, 32'd0, 1'b0});
        rows.push_back('{OP_LOOKUP, 32'd0, 32'd0, 1'b1, ST_OK, 32'h7fff_ffff, 1'b0});
        rows.push_back('{OP_LOOKUP, 32'h7fff_ffff, 32'd9, 1'b1, ST_OK, 32'h8000_0000, 1'b0});
        rows.push_back('{OP_LOOKUP, 32'hffff_ffff, 32'd0, 1'b1, ST_NOT_FOUND, 32'd0, 1'b0});
        rows.push_back('{OP_LOOKUP, 32'h8000_0000, 32'd0, 1'b1, ST_NOT_FOUND, 32'd0, 1'b0});
        rows.push_back('{OP_REMOVE, 32'd0, 32'd0, 1'b1, ST_OK, 32'h7fff_ffff, 1'b0});
        rows.push_back('{OP_LOOKUP, 32'd0, 32'd0, 1'b0, ST_OK, 32'd0, 1'b0});
        rows.push_back('{OP_REMOVE, 32'h7fff_ffff, 32'd0, 1'b0, ST_OK, 32'd0, 1'b0});
        rows.push_back('{OP_LOOKUP, 32'h7fff_ffff, 32'd0, 1'b0, ST_OK, 32'd0, 1'b0});
        rows.push_back('{OP_REMOVE, 32'h0001_2345, 32'd0, 1'b1, ST_NOT_FOUND, 32'd0, 1'b0});
        rows.push_back('{OP_NONE, 32'd0, 32'd0, 1'b1, ST_OK, 32'd0, 1'b0});
        rows.push_back('{OP_INSERT, 32'h4000_0000, 32'ha5a5_a5a5, 1'b0, ST_OK, 32'd0, 1'b0});
        rows.push_back('{OP_INSERT, 32'd1, 32'h5a5a_5a5a, 1'b0, ST_OK, 32'd0, 1'b0});

        foreach (rows[i])
            send_beat(rows[i].op, rows[i].k, rows[i].d, rows[i].pinned,
                      '{rows[i].st, rows[i].value, 1'(rows[i].empty)});

        // four entries are held now; descending keys fill the rest
        for (i = 0; i < ENTRIES - 4; i++)
            send_beat(OP_INSERT, 32'(1000 - 7 * i), $urandom, 1'b0, none);
        send_beat(OP_INSERT, 32'd5, 32'd3, 1'b1, '{ST_FULL, 32'd0, 1'b0});
        // sign check wins over the full check
        send_beat(OP_INSERT, 32'hffff_ffff, 32'd3, 1'b1, '{ST_NEGATIVE, 32'd0, 1'b0});
        send_beat(OP_LOOKUP, 32'd1000, 32'd0, 1'b0, none);
        send_beat(OP_LOOKUP, 32'h4000_0000, 32'd0, 1'b0, none);
        wait_results_drained();

        // long receiver hold-off while the sender keeps offering
        hold_len = 300;
        hold_requests++;
        run_phase(0, 0, 170);
        run_phase(65, 0, 170);
        run_phase(0, 65, 170);
        run_phase(8, 8, 170);

        wait_results_drained();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
